[rtl/cross_neighborhood_class_assign_core_macros.svh]
// Assertion macros for the cross-neighborhood class assignment core.
// Included by the modules that check their own logic; needs clk and rst in scope.
`ifndef CROSS_NEIGHBORHOOD_CLASS_ASSIGN_CORE_MACROS_SVH
`define CROSS_NEIGHBORHOOD_CLASS_ASSIGN_CORE_MACROS_SVH

`ifndef ASSERT_OFF

// Check a property on every clock edge outside reset.
`define CNCA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that a condition in one cycle implies another in the next.
`define CNCA_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`else

`define CNCA_ASSERT(label, prop, msg)

`define CNCA_ASSERT_NEXT(label, pre, post, msg)

`endif

`endif

[rtl/cnca_pkg.sv]
// Shared types and constants of the cross-neighborhood class assignment core.
// No dependencies; used by the sort, cell, count and top-level files.
package cnca_pkg;

  // Pixel and cross geometry
  localparam int PIX_W      = 8;
  localparam int CROSS_SIZE = 5;
  localparam int GREY_MAX   = 255;

  // Sum of five absolute differences of 8-bit values fits in 11 bits
  localparam int DIST_W = 11;

  // Positions reported with each result
  localparam int POS_W = 12;

  // Member counters
  localparam int COUNT_W = 24;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // Configuration port
  localparam int CFG_W       = 13;
  localparam int CFG_CLASS_W = 5;
  localparam int REG_IDX_W   = 2;

  localparam logic [REG_IDX_W-1:0] REG_LINE_WIDTH   = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_CLASS_COUNT  = 2'd2;

  localparam logic [CFG_W-1:0]       LINE_WIDTH_RESET   = 13'd640;
  localparam logic [CFG_W-1:0]       FRAME_HEIGHT_RESET = 13'd480;
  localparam logic [CFG_CLASS_W-1:0] CLASS_COUNT_RESET  = 5'd2;

  localparam logic [CFG_W-1:0] DIM_MIN    = 13'd3;
  localparam logic [CFG_W-1:0] HEIGHT_MAX = 13'd4096;
  localparam int               CLASS_MIN  = 2;

  // Parameter defaults
  localparam int MAX_WIDTH_DEF   = 4096;
  localparam int MAX_CLASSES_DEF = 16;

  // Five neighborhood values
  typedef logic [CROSS_SIZE-1:0][PIX_W-1:0] cross_t;

  // Control bits that travel with each item down the pipeline
  typedef struct packed {
    logic valid;    // stage holds an item
    logic produce;  // item yields a result
    logic clear;    // item starts a frame: clear the member counts
  } ctrl_t;

endpackage

[rtl/cnca_ifs.sv]
// Stream interfaces of the cross-neighborhood class assignment core.
// Depends on nothing; valid/ready handshake with payload.
interface cnca_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] grey_value;

  modport source (output valid, output grey_value, input ready);
  modport sink   (input valid, input grey_value, output ready);
endinterface

interface cnca_result_if;
  logic        valid;
  logic        ready;
  logic [7:0]  sorted_first;
  logic [7:0]  sorted_second;
  logic [7:0]  sorted_third;
  logic [7:0]  sorted_fourth;
  logic [7:0]  sorted_fifth;
  logic [3:0]  class_index;
  logic [23:0] class_members;
  logic [11:0] center_row;
  logic [11:0] center_col;

  modport source (
    output valid, input ready,
    output sorted_first, output sorted_second, output sorted_third,
    output sorted_fourth, output sorted_fifth,
    output class_index, output class_members, output center_row, output center_col
  );
  modport sink (
    input valid, output ready,
    input sorted_first, input sorted_second, input sorted_third,
    input sorted_fourth, input sorted_fifth,
    input class_index, input class_members, input center_row, input center_col
  );
endinterface

[rtl/cnca_sort.sv]
// Five-value sorting network with one register stage.
// Depends on cnca_pkg for the cross and control types.
module cnca_sort (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  cnca_pkg::ctrl_t      ctrl_in,
  input  cnca_pkg::cross_t     vals_in,
  input  logic [11:0]          row_in,
  input  logic [11:0]          col_in,
  output cnca_pkg::ctrl_t      ctrl_out,
  output cnca_pkg::cross_t     vals_out,
  output logic [11:0]          row_out,
  output logic [11:0]          col_out
);

  cnca_pkg::cross_t sorted;

  // Nine compare-exchange steps, depth five
  always_comb begin
    logic [cnca_pkg::PIX_W-1:0] tmp;
    tmp = '0;
    sorted = vals_in;
    if (sorted[0] > sorted[3]) begin
      tmp = sorted[0]; sorted[0] = sorted[3]; sorted[3] = tmp;
    end
    if (sorted[1] > sorted[4]) begin
      tmp = sorted[1]; sorted[1] = sorted[4]; sorted[4] = tmp;
    end
    if (sorted[0] > sorted[2]) begin
      tmp = sorted[0]; sorted[0] = sorted[2]; sorted[2] = tmp;
    end
    if (sorted[1] > sorted[3]) begin
      tmp = sorted[1]; sorted[1] = sorted[3]; sorted[3] = tmp;
    end
    if (sorted[0] > sorted[1]) begin
      tmp = sorted[0]; sorted[0] = sorted[1]; sorted[1] = tmp;
    end
    if (sorted[2] > sorted[4]) begin
      tmp = sorted[2]; sorted[2] = sorted[4]; sorted[4] = tmp;
    end
    if (sorted[1] > sorted[2]) begin
      tmp = sorted[1]; sorted[1] = sorted[2]; sorted[2] = tmp;
    end
    if (sorted[3] > sorted[4]) begin
      tmp = sorted[3]; sorted[3] = sorted[4]; sorted[4] = tmp;
    end
    if (sorted[2] > sorted[3]) begin
      tmp = sorted[2]; sorted[2] = sorted[3]; sorted[3] = tmp;
    end
  end

  // Advance the control bits
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_out <= '0;
    end else if (adv) begin
      ctrl_out <= ctrl_in;
    end
  end

  // Advance the payload
  always_ff @(posedge clk) begin
    if (adv) begin
      vals_out <= sorted;
      row_out  <= row_in;
      col_out  <= col_in;
    end
  end

endmodule

[rtl/cnca_cell.sv]
// One class cell: distance of the sorted cross to this class's center,
// compared with the best so far, registered and handed on to the next cell.
// Depends on cnca_pkg.
module cnca_cell #(
  parameter int INDEX       = 0,
  parameter int MAX_CLASSES = cnca_pkg::MAX_CLASSES_DEF,
  localparam int IDX_W      = $clog2(MAX_CLASSES),
  localparam int KC_W       = $clog2(MAX_CLASSES + 1)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         adv,
  input  logic [KC_W-1:0]              class_count,
  input  logic [7:0]                   step,
  input  cnca_pkg::ctrl_t              ctrl_in,
  input  cnca_pkg::cross_t             vals_in,
  input  logic [11:0]                  row_in,
  input  logic [11:0]                  col_in,
  input  logic [7:0]                   center_in,
  input  logic [cnca_pkg::DIST_W-1:0]  best_dist_in,
  input  logic [IDX_W-1:0]             best_idx_in,
  output cnca_pkg::ctrl_t              ctrl_out,
  output cnca_pkg::cross_t             vals_out,
  output logic [11:0]                  row_out,
  output logic [11:0]                  col_out,
  output logic [7:0]                   center_out,
  output logic [cnca_pkg::DIST_W-1:0]  best_dist_out,
  output logic [IDX_W-1:0]             best_idx_out
);

  logic                        active;
  logic [cnca_pkg::DIST_W-1:0] sad;
  logic                        take;

  // Cells past the configured class count keep the best distance and class unchanged
  assign active = KC_W'(INDEX) < class_count;

  // Sum of absolute differences to this center
  always_comb begin
    logic [7:0] diff;
    sad = '0;
    for (int k = 0; k < cnca_pkg::CROSS_SIZE; k++) begin
      diff = (vals_in[k] >= center_in) ? (vals_in[k] - center_in) : (center_in - vals_in[k]);
      sad = sad + cnca_pkg::DIST_W'(diff);
    end
  end

  // Only a strictly smaller sum switches class
  assign take = active && (sad < best_dist_in);

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_out <= '0;
    end else if (adv) begin
      ctrl_out <= ctrl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      vals_out      <= vals_in;
      row_out       <= row_in;
      col_out       <= col_in;
      center_out    <= center_in + step;
      best_dist_out <= take ? sad : best_dist_in;
      best_idx_out  <= take ? IDX_W'(INDEX) : best_idx_in;
    end
  end

endmodule

[rtl/cnca_count.sv]
// Per-class member counters: cleared at frame start, saturating increment
// for each classified pixel. Depends on cnca_pkg.
module cnca_count #(
  parameter int MAX_CLASSES = cnca_pkg::MAX_CLASSES_DEF,
  localparam int IDX_W      = $clog2(MAX_CLASSES)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          adv,
  input  cnca_pkg::ctrl_t               ctrl_in,
  input  logic [IDX_W-1:0]              idx_in,
  output logic [cnca_pkg::COUNT_W-1:0]  members
);

  logic [cnca_pkg::COUNT_W-1:0] counts [MAX_CLASSES];
  logic [cnca_pkg::COUNT_W-1:0] current;

  // Count after this pixel, held at the top
  assign current = counts[idx_in];
  assign members = (current == cnca_pkg::COUNT_MAX) ? current
                                                     : current + cnca_pkg::COUNT_W'(1);

  // Clear on frame start, update the chosen class on a result
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_CLASSES; i++) begin
        counts[i] <= '0;
      end
    end else if (adv && ctrl_in.valid) begin
      if (ctrl_in.clear) begin
        for (int i = 0; i < MAX_CLASSES; i++) begin
          counts[i] <= '0;
        end
      end else if (ctrl_in.produce) begin
        counts[idx_in] <= members;
      end
    end
  end

endmodule

[rtl/cross_neighborhood_class_assign_core.sv]
// Cross-neighborhood class assignment: takes one grey pixel per cycle in raster
// order unless the output buffer is full and, for each interior pixel, returns
// the five cross values sorted, the nearest of class_count evenly spaced grey
// centers by summed absolute distance, that class's saturating member count for
// the frame, and the pixel's row and column. Border pixels give no result. The
// core sustains one pixel per clock unless the output buffer is full: the line
// buffer is one memory read and written once per pixel, and the class search
// runs down a chain of MAX_CLASSES registered cells. A result passes stage 1,
// stage 2, the sort register and the cell chain before the output buffer. A
// two-entry output buffer keeps input accepted while one result waits.
// Depends on cnca_pkg, cnca_ifs, cnca_sort, cnca_cell, cnca_count.
`include "cross_neighborhood_class_assign_core_macros.svh"

module cross_neighborhood_class_assign_core #(
  parameter int MAX_WIDTH   = cnca_pkg::MAX_WIDTH_DEF,
  parameter int MAX_CLASSES = cnca_pkg::MAX_CLASSES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [cnca_pkg::REG_IDX_W-1:0]    cfg_index,
  input  logic [cnca_pkg::CFG_W-1:0]        cfg_data,
  cnca_pixel_if.sink                        pixel_in,
  cnca_result_if.source                     result_out
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int WID_W = $clog2(MAX_WIDTH + 1);
  localparam int IDX_W = $clog2(MAX_CLASSES);
  localparam int KC_W  = $clog2(MAX_CLASSES + 1);
  localparam int PW    = cnca_pkg::PIX_W;

  typedef struct packed {
    cnca_pkg::cross_t             vals;
    logic [3:0]                   class_index;
    logic [cnca_pkg::COUNT_W-1:0] class_members;
    logic [11:0]                  center_row;
    logic [11:0]                  center_col;
  } result_t;

  // Configuration registers
  logic [cnca_pkg::CFG_W-1:0]       line_width;
  logic [cnca_pkg::CFG_W-1:0]       frame_height;
  logic [cnca_pkg::CFG_CLASS_W-1:0] class_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width   <= cnca_pkg::LINE_WIDTH_RESET;
      frame_height <= cnca_pkg::FRAME_HEIGHT_RESET;
      class_count  <= cnca_pkg::CLASS_COUNT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        cnca_pkg::REG_LINE_WIDTH:   line_width   <= cfg_data;
        cnca_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data;
        cnca_pkg::REG_CLASS_COUNT:  class_count  <= cfg_data[cnca_pkg::CFG_CLASS_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the registers to their working ranges
  logic [WID_W-1:0]          width_eff;
  logic [cnca_pkg::CFG_W-1:0] height_eff;
  logic [KC_W-1:0]           classes_eff;

  always_comb begin
    if (line_width < cnca_pkg::DIM_MIN) begin
      width_eff = WID_W'(3);
    end else if (32'(line_width) > 32'(MAX_WIDTH)) begin
      width_eff = WID_W'(MAX_WIDTH);
    end else begin
      width_eff = WID_W'(line_width);
    end

    if (frame_height < cnca_pkg::DIM_MIN) begin
      height_eff = cnca_pkg::DIM_MIN;
    end else if (frame_height > cnca_pkg::HEIGHT_MAX) begin
      height_eff = cnca_pkg::HEIGHT_MAX;
    end else begin
      height_eff = frame_height;
    end

    if (32'(class_count) < 32'(cnca_pkg::CLASS_MIN)) begin
      classes_eff = KC_W'(cnca_pkg::CLASS_MIN);
    end else if (32'(class_count) > 32'(MAX_CLASSES)) begin
      classes_eff = KC_W'(MAX_CLASSES);
    end else begin
      classes_eff = KC_W'(class_count);
    end
  end

  // Center spacing for each class count, worked out at elaboration
  logic [7:0] step_tab [MAX_CLASSES + 1];
  logic [7:0] step;

  for (genvar n = 0; n <= MAX_CLASSES; n++) begin : g_step
    if (n >= 2) begin : g_real
      localparam int Step = cnca_pkg::GREY_MAX / (n - 1);
      assign step_tab[n] = 8'(Step);
    end else begin : g_unused
      assign step_tab[n] = 8'd0;
    end
  end

  assign step = step_tab[classes_eff];

  // Output buffer state and pipeline advance
  logic    out_valid;
  logic    skid_valid;
  result_t out_data;
  result_t skid_data;
  logic    adv;
  logic    accept;
  logic    take;

  assign adv            = !skid_valid;
  assign pixel_in.ready = adv;
  assign accept         = pixel_in.valid && adv;
  assign take           = out_valid && result_out.ready;

  // Raster position of the next pixel
  logic [COL_W-1:0]           col;
  logic [11:0]                row;
  logic [WID_W-1:0]           col_inc;
  logic [cnca_pkg::CFG_W-1:0] row_inc;

  assign col_inc = WID_W'(col) + WID_W'(1);
  assign row_inc = cnca_pkg::CFG_W'(row) + cnca_pkg::CFG_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if (col_inc >= width_eff) begin
        col <= '0;
        row <= (row_inc >= height_eff) ? 12'd0 : row_inc[11:0];
      end else begin
        col <= COL_W'(col_inc);
      end
    end
  end

  // Stage 1: accepted pixel, line buffer read under way
  cnca_pkg::ctrl_t s1_ctrl;
  logic [PW-1:0]   s1_pix;
  logic [COL_W-1:0] s1_col;
  logic [11:0]     s1_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctrl <= '0;
    end else if (adv) begin
      s1_ctrl.valid   <= accept;
      s1_ctrl.produce <= accept && (row >= 12'd2) && (col >= COL_W'(2));
      s1_ctrl.clear   <= accept && (row == 12'd0) && (col == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix <= pixel_in.grey_value;
      s1_col <= col;
      s1_row <= row;
    end
  end

  // Line buffer: each entry holds {upper line, middle line} for one column
  logic [2*PW-1:0] line_mem [MAX_WIDTH];
  logic [2*PW-1:0] line_rd;
  logic [PW-1:0]   up_val;
  logic [PW-1:0]   mid_val;

  assign up_val  = line_rd[2*PW-1:PW];
  assign mid_val = line_rd[PW-1:0];

  always_ff @(posedge clk) begin
    if (accept) begin
      line_rd <= line_mem[col];
    end
    if (adv && s1_ctrl.valid) begin
      line_mem[s1_col] <= {mid_val, s1_pix};
    end
  end

  // Window of the pending cross
  logic [PW-1:0] win_up;
  logic [PW-1:0] win_left;
  logic [PW-1:0] win_mid;
  logic [PW-1:0] prev_pix;

  always_ff @(posedge clk) begin
    if (adv && s1_ctrl.valid) begin
      win_up   <= up_val;
      win_left <= win_mid;
      win_mid  <= mid_val;
      prev_pix <= s1_pix;
    end
  end

  // Stage 2: gathered cross and center position
  cnca_pkg::ctrl_t  s2_ctrl;
  cnca_pkg::cross_t s2_vals;
  logic [11:0]      s2_row;
  logic [11:0]      s2_col;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_ctrl <= '0;
    end else if (adv) begin
      s2_ctrl <= s1_ctrl;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_vals[0] <= win_mid;
      s2_vals[1] <= win_up;
      s2_vals[2] <= prev_pix;
      s2_vals[3] <= win_left;
      s2_vals[4] <= mid_val;
      s2_row     <= s1_row - 12'd1;
      s2_col     <= 12'(s1_col - COL_W'(1));
    end
  end

  // Sort, then walk the chain of class cells
  cnca_pkg::ctrl_t             chain_ctrl   [MAX_CLASSES + 1];
  cnca_pkg::cross_t            chain_vals   [MAX_CLASSES + 1];
  logic [11:0]                 chain_row    [MAX_CLASSES + 1];
  logic [11:0]                 chain_col    [MAX_CLASSES + 1];
  logic [7:0]                  chain_center [MAX_CLASSES + 1];
  logic [cnca_pkg::DIST_W-1:0] chain_dist   [MAX_CLASSES + 1];
  logic [IDX_W-1:0]            chain_idx    [MAX_CLASSES + 1];

  cnca_sort u_sort (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .ctrl_in  (s2_ctrl),
    .vals_in  (s2_vals),
    .row_in   (s2_row),
    .col_in   (s2_col),
    .ctrl_out (chain_ctrl[0]),
    .vals_out (chain_vals[0]),
    .row_out  (chain_row[0]),
    .col_out  (chain_col[0])
  );

  // Class 0 sits at black and beats any starting distance
  assign chain_center[0] = 8'd0;
  assign chain_dist[0]   = '1;
  assign chain_idx[0]    = '0;

  for (genvar i = 0; i < MAX_CLASSES; i++) begin : g_cell
    cnca_cell #(
      .INDEX       (i),
      .MAX_CLASSES (MAX_CLASSES)
    ) u_cell (
      .clk           (clk),
      .rst           (rst),
      .adv           (adv),
      .class_count   (classes_eff),
      .step          (step),
      .ctrl_in       (chain_ctrl[i]),
      .vals_in       (chain_vals[i]),
      .row_in        (chain_row[i]),
      .col_in        (chain_col[i]),
      .center_in     (chain_center[i]),
      .best_dist_in  (chain_dist[i]),
      .best_idx_in   (chain_idx[i]),
      .ctrl_out      (chain_ctrl[i+1]),
      .vals_out      (chain_vals[i+1]),
      .row_out       (chain_row[i+1]),
      .col_out       (chain_col[i+1]),
      .center_out    (chain_center[i+1]),
      .best_dist_out (chain_dist[i+1]),
      .best_idx_out  (chain_idx[i+1])
    );
  end

  // Member counts of the chosen class
  logic [cnca_pkg::COUNT_W-1:0] members;

  cnca_count #(
    .MAX_CLASSES (MAX_CLASSES)
  ) u_count (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .ctrl_in (chain_ctrl[MAX_CLASSES]),
    .idx_in  (chain_idx[MAX_CLASSES]),
    .members (members)
  );

  // Result leaving the chain
  result_t res;
  logic    res_valid;

  assign res.vals          = chain_vals[MAX_CLASSES];
  assign res.class_index   = 4'(chain_idx[MAX_CLASSES]);
  assign res.class_members = members;
  assign res.center_row    = chain_row[MAX_CLASSES];
  assign res.center_col    = chain_col[MAX_CLASSES];
  assign res_valid = adv && chain_ctrl[MAX_CLASSES].valid && chain_ctrl[MAX_CLASSES].produce;

  // Output register with a skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (take) begin
        skid_valid <= 1'b0;
      end
    end else if (res_valid) begin
      if (out_valid && !take) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (take) begin
        out_data <= skid_data;
      end
    end else if (res_valid) begin
      if (out_valid && !take) begin
        skid_data <= res;
      end else begin
        out_data <= res;
      end
    end
  end

  assign result_out.valid         = out_valid;
  assign result_out.sorted_first  = out_data.vals[0];
  assign result_out.sorted_second = out_data.vals[1];
  assign result_out.sorted_third  = out_data.vals[2];
  assign result_out.sorted_fourth = out_data.vals[3];
  assign result_out.sorted_fifth  = out_data.vals[4];
  assign result_out.class_index   = out_data.class_index;
  assign result_out.class_members = out_data.class_members;
  assign result_out.center_row    = out_data.center_row;
  assign result_out.center_col    = out_data.center_col;

  // Checks
  `CNCA_ASSERT(a_skid_behind_out, skid_valid |-> out_valid,
    "skid entry held with empty output register")
  `CNCA_ASSERT(a_skid_on_stall,
    $rose(skid_valid) |-> $past(result_out.valid) && !$past(result_out.ready),
    "skid entry filled without an output stall")
  `CNCA_ASSERT_NEXT(a_skid_drains, skid_valid && result_out.ready,
    !skid_valid && result_out.valid, "skid entry not moved to output register")
  `CNCA_ASSERT(a_sorted,
    result_out.valid |-> (result_out.sorted_first <= result_out.sorted_second) &&
    (result_out.sorted_second <= result_out.sorted_third) &&
    (result_out.sorted_third <= result_out.sorted_fourth) &&
    (result_out.sorted_fourth <= result_out.sorted_fifth),
    "cross values out of order")
  `CNCA_ASSERT(a_interior_row, result_out.valid |-> (result_out.center_row != 12'd0),
    "result for a top border pixel")

endmodule
